FILE: rtl/rkx_pkg.sv
package rkx_pkg;

	localparam int KEY_IDX_W = 6;
	localparam int OBUF_DEPTH = 4;
	localparam int OBUF_AW = 2;
	localparam int OBUF_CW = 3;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} rkx_word_t;

	function automatic logic [7:0] base_key(input logic [KEY_IDX_W-1:0] idx);
		logic [7:0] k;
		case (idx)
			6'd0:    k = 8'h21;
			6'd1:    k = 8'h23;
			6'd2:    k = 8'h31;
			6'd3:    k = 8'h2A;
			6'd4:    k = 8'h33;
			6'd5:    k = 8'h29;
			6'd6:    k = 8'h2D;
			6'd7:    k = 8'h7E;
			6'd8:    k = 8'h40;
			6'd9:    k = 8'h2A;
			6'd10:   k = 8'h25;
			6'd11:   k = 8'h65;
			6'd12:   k = 8'h24;
			6'd13:   k = 8'h78;
			6'd14:   k = 8'h3D;
			6'd15:   k = 8'h5D;
			default: k = 8'h00;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] seed_mask(input logic [KEY_IDX_W-1:0] idx);
		logic [7:0] k;
		case (idx)
			6'd0:    k = 8'h72;
			6'd1:    k = 8'h2A;
			6'd2:    k = 8'h6A;
			6'd3:    k = 8'h26;
			6'd4:    k = 8'h79;
			6'd5:    k = 8'h25;
			6'd6:    k = 8'h32;
			6'd7:    k = 8'h28;
			6'd8:    k = 8'h30;
			6'd9:    k = 8'h29;
			6'd10:   k = 8'h40;
			6'd11:   k = 8'h7E;
			6'd12:   k = 8'h3B;
			6'd13:   k = 8'h6D;
			6'd14:   k = 8'h2E;
			6'd15:   k = 8'h4B;
			6'd16:   k = 8'h27;
			6'd17:   k = 8'h70;
			6'd18:   k = 8'h48;
			6'd19:   k = 8'h5E;
			6'd20:   k = 8'h5B;
			6'd21:   k = 8'h24;
			6'd22:   k = 8'h3F;
			6'd23:   k = 8'h44;
			6'd24:   k = 8'h37;
			6'd25:   k = 8'h23;
			6'd26:   k = 8'h2F;
			6'd27:   k = 8'h55;
			6'd28:   k = 8'h7C;
			6'd29:   k = 8'h34;
			6'd30:   k = 8'h56;
			6'd31:   k = 8'h2B;
			default: k = 8'h00;
		endcase
		return k;
	endfunction

endpackage

FILE: rtl/repeating_key_xor_obfuscator_top.sv
// Repeating-key XOR obfuscator.
// Input channel: in_valid / in_stall with data_byte and last, one word per
// message byte. Output channel: out_valid / out_stall with out_byte and
// out_last, one word per encoded byte in message order.
// The first SEED_POSITION bytes of a message go into an on-chip hold memory
// and produce no output. A last flag before the seed position releases the
// held bytes under the default key; the byte at the seed position releases
// the held bytes under the seeded key, then the seed byte itself.
// The burst is read from the hold memory at one word per cycle while the
// output queue has space; the input is stalled while it drains and while
// the seed byte is sent.
// After the seed, each accepted byte is encoded through the s1 registers
// and queued at one word per cycle while the input is not stalled.
// Results pass through a 4-word output queue; when the receiver stalls the
// queue fills and in_stall rises, no word is dropped.
// Reset clears all control state; the next byte starts a new message.
module repeating_key_xor_obfuscator_top
	import rkx_pkg::*;
#(
	parameter int SEED_POSITION = 13,
	parameter int SHORT_KEY_LEN = 16,
	parameter int LONG_KEY_LEN  = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	localparam int AW = (SEED_POSITION > 1) ? $clog2(SEED_POSITION) : 1;
	localparam int PW = $clog2(SEED_POSITION + 1);
	localparam logic [KEY_IDX_W-1:0] SHORT_LAST = KEY_IDX_W'(SHORT_KEY_LEN - 1);
	localparam logic [KEY_IDX_W-1:0] LONG_LAST  = KEY_IDX_W'(LONG_KEY_LEN - 1);
	localparam logic [KEY_IDX_W-1:0] STREAM_KEY0 =
		KEY_IDX_W'((SEED_POSITION + 1) % LONG_KEY_LEN);
	localparam logic [PW-1:0] SEED_POS = PW'(SEED_POSITION);
	localparam logic [AW-1:0] SEED_LAST_ADDR = AW'(SEED_POSITION - 1);

	localparam logic [1:0] ST_HOLD   = 2'd0;
	localparam logic [1:0] ST_DRAIN  = 2'd1;
	localparam logic [1:0] ST_SEED   = 2'd2;
	localparam logic [1:0] ST_STREAM = 2'd3;

	logic [7:0]           hold_mem [SEED_POSITION];
	logic [7:0]           rd_data_q;

	logic [1:0]           st_q;
	logic [PW-1:0]        pos_q;
	logic [AW-1:0]        rd_idx_q;
	logic [AW-1:0]        end_idx_q;
	logic [KEY_IDX_W-1:0] kpos_q;
	logic [KEY_IDX_W-1:0] kidx_q;
	logic [7:0]           seed_q;
	logic                 seed_last_q;
	logic                 long_q;

	logic                 v_s1;
	logic                 mem_s1;
	logic [7:0]           dir_s1;
	logic [7:0]           key_s1;
	logic                 last_s1;

	logic                 space;
	logic                 acc;
	logic                 issue_v;
	logic                 issue_mem;
	logic [7:0]           issue_dir;
	logic [7:0]           issue_key;
	logic                 issue_last;
	logic [KEY_IDX_W-1:0] kpos_wrap;

	rkx_word_t            push_word;
	rkx_word_t            head;
	logic [OBUF_CW-1:0]   count;
	logic                 pop;

	assign space    = ({1'b0, count} + (OBUF_CW + 1)'(v_s1)) < (OBUF_CW + 1)'(OBUF_DEPTH);
	assign in_stall = (st_q inside {ST_DRAIN, ST_SEED}) || !space;
	assign acc      = in_valid && !in_stall;
	assign kpos_wrap = long_q ? LONG_LAST : SHORT_LAST;

	always_comb begin
		issue_v    = 1'b0;
		issue_mem  = 1'b0;
		issue_dir  = data_byte;
		issue_key  = 8'h00;
		issue_last = 1'b0;
		case (st_q)
			ST_DRAIN: begin
				issue_v    = space;
				issue_mem  = 1'b1;
				issue_key  = long_q ? (seed_q ^ seed_mask(kpos_q)) : base_key(kpos_q);
				issue_last = !long_q && (rd_idx_q == end_idx_q);
			end
			ST_SEED: begin
				issue_v    = space;
				issue_dir  = seed_q;
				issue_last = seed_last_q;
			end
			ST_STREAM: begin
				issue_v    = acc;
				issue_key  = seed_q ^ seed_mask(kidx_q);
				issue_last = last;
			end
			default: begin
				issue_v = 1'b0;
			end
		endcase
	end

	// hold memory: write during collection, read during drain
	always_ff @(posedge clk) begin
		if (acc && (st_q == ST_HOLD) && (pos_q != SEED_POS)) begin
			hold_mem[AW'(pos_q)] <= data_byte;
		end
		rd_data_q <= hold_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_HOLD;
			pos_q       <= '0;
			rd_idx_q    <= '0;
			end_idx_q   <= '0;
			kpos_q      <= '0;
			kidx_q      <= '0;
			seed_q      <= '0;
			seed_last_q <= 1'b0;
			long_q      <= 1'b0;
		end else begin
			case (st_q)
				ST_HOLD: begin
					if (acc) begin
						if (pos_q == SEED_POS) begin
							seed_q      <= data_byte;
							seed_last_q <= last;
							long_q      <= 1'b1;
							end_idx_q   <= SEED_LAST_ADDR;
							rd_idx_q    <= '0;
							kpos_q      <= '0;
							pos_q       <= '0;
							st_q        <= ST_DRAIN;
						end else if (last) begin
							long_q    <= 1'b0;
							end_idx_q <= AW'(pos_q);
							rd_idx_q  <= '0;
							kpos_q    <= '0;
							pos_q     <= '0;
							st_q      <= ST_DRAIN;
						end else begin
							pos_q <= pos_q + PW'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (space) begin
						if (rd_idx_q == end_idx_q) begin
							st_q <= long_q ? ST_SEED : ST_HOLD;
						end else begin
							rd_idx_q <= rd_idx_q + AW'(1);
							kpos_q   <= (kpos_q == kpos_wrap) ? '0 : kpos_q + KEY_IDX_W'(1);
						end
					end
				end
				ST_SEED: begin
					if (space) begin
						kidx_q <= STREAM_KEY0;
						st_q   <= seed_last_q ? ST_HOLD : ST_STREAM;
					end
				end
				ST_STREAM: begin
					if (acc) begin
						kidx_q <= (kidx_q == LONG_LAST) ? '0 : kidx_q + KEY_IDX_W'(1);
						if (last) begin
							st_q <= ST_HOLD;
						end
					end
				end
				default: begin
					st_q <= ST_HOLD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue_v;
		end
	end

	always_ff @(posedge clk) begin
		mem_s1  <= issue_mem;
		dir_s1  <= issue_dir;
		key_s1  <= issue_key;
		last_s1 <= issue_last;
	end

	assign push_word.data = (mem_s1 ? rd_data_q : dir_s1) ^ key_s1;
	assign push_word.last = last_s1;
	assign out_valid      = (count != '0);
	assign pop            = out_valid && !out_stall;

	rkx_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s1),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.count     (count)
	);

	assign out_byte = head.data;
	assign out_last = head.last;

`ifndef NO_ASSERTIONS
	a_drain_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DRAIN || st_q == ST_SEED) |-> in_stall)
		else $error("input taken during burst");

	a_seed_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && st_q == ST_HOLD && pos_q == SEED_POS) |=> (st_q == ST_DRAIN && long_q))
		else $error("seed byte did not start the burst");

	a_mem_word_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && mem_s1) |-> $past(st_q == ST_DRAIN))
		else $error("memory word outside burst");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= OBUF_CW'(OBUF_DEPTH))
		else $error("output queue overrun");
`endif

endmodule

FILE: rtl/rkx_obuf.sv
module rkx_obuf
	import rkx_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rkx_word_t            push_word,
	input  logic                 pop,
	output rkx_word_t            head,
	output logic [OBUF_CW-1:0]   count
);

	rkx_word_t          buf_q [OBUF_DEPTH];
	logic [OBUF_AW-1:0] wr_ptr_q;
	logic [OBUF_AW-1:0] rd_ptr_q;
	logic [OBUF_CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OBUF_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OBUF_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OBUF_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - OBUF_CW'(1);
			end
		end
	end

	assign head  = buf_q[rd_ptr_q];
	assign count = cnt_q;

endmodule
